[rtl/core/gcpa_pkg.sv]
// Shared types and constants for the GBM call payoff accumulator.
// Holds the exp fraction table generator used by gcpa_rom at elaboration.
// No dependencies.
package gcpa_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned PriceW   = 32;
  localparam int unsigned DiffW    = 31;
  localparam int unsigned SumW     = 64;
  localparam int unsigned CountW   = 40;
  localparam int unsigned XW       = 36;
  localparam int unsigned YW       = 24;
  localparam int unsigned MulW     = 33;
  localparam int unsigned ProdW    = 2 * MulW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned OutDataW = 112;

  localparam logic [30:0]         Log2eQ30 = 31'd1549082005;
  localparam logic [63:0]         Ln2Q32   = 64'd2977044472;
  localparam logic signed [XW-1:0] XLimit  = 36'sd4194304;

  localparam logic [PriceW-1:0] SpotReset   = 32'd6553600;
  localparam logic [PriceW-1:0] StrikeReset = 32'd6553600;
  localparam logic [PriceW-1:0] DriftReset  = 32'd1966;
  localparam logic [DiffW-1:0]  DiffReset   = 31'd13107;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPOT   = 2'd0,
    CFG_STRIKE = 2'd1,
    CFG_DRIFT  = 2'd2,
    CFG_DIFF   = 2'd3
  } cfg_idx_e;

  // exponent range status of the current transaction
  typedef struct packed {
    logic hi;
    logic lo;
  } gcpa_range_t;

  // 2^(idx / 2^bits) in Q2.30, Taylor series of exp(idx/2^bits * ln2)
  function automatic logic [31:0] frac_entry(input int unsigned idx, input int unsigned bits);
    logic [63:0] u;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] prod;
    u    = 64'(idx) << (32 - bits);
    t    = (u * Ln2Q32) >> 32;
    term = 64'd1 << 32;
    sum  = 64'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      prod = (term * t) >> 32;
      case (k)
        2:       term = prod / 64'd2;
        3:       term = prod / 64'd3;
        4:       term = prod / 64'd4;
        5:       term = prod / 64'd5;
        6:       term = prod / 64'd6;
        7:       term = prod / 64'd7;
        8:       term = prod / 64'd8;
        9:       term = prod / 64'd9;
        10:      term = prod / 64'd10;
        11:      term = prod / 64'd11;
        12:      term = prod / 64'd12;
        default: term = prod;
      endcase
      sum = sum + term;
    end
    return 32'((sum + 64'd2) >> 2);
  endfunction

endpackage

[rtl/core/gcpa_mul.sv]
// Shared signed 33x33 multiplier used by every product of the pricing sequence.
// Depends on gcpa_pkg.
module gcpa_mul (
  input  logic signed [gcpa_pkg::MulW-1:0]  a_i,
  input  logic signed [gcpa_pkg::MulW-1:0]  b_i,
  output logic signed [gcpa_pkg::ProdW-1:0] p_o
);
  import gcpa_pkg::*;

  assign p_o = ProdW'(a_i) * ProdW'(b_i);

endmodule

[rtl/core/gcpa_rom.sv]
// Fraction table 2^(i/2^BITS) in Q2.30 with registered read.
// Depends on gcpa_pkg (frac_entry).
module gcpa_rom #(
  parameter int unsigned EXP_TABLE_BITS = 10
) (
  input  logic                      clk_i,
  input  logic [EXP_TABLE_BITS-1:0] addr_i,
  output logic [31:0]               data_o
);
  import gcpa_pkg::*;

  localparam int unsigned TableSize = 1 << EXP_TABLE_BITS;

  typedef logic [31:0] rom_t [TableSize];

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned i = 0; i < TableSize; i++) begin
      r[i] = frac_entry(i, EXP_TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t Rom = build_rom();

  logic [31:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= Rom[addr_i];
  end

  assign data_o = data_q;

endmodule

[rtl/core/gcpa_scale.sv]
// Scales spot*table product by 2^(n-30) with saturation and range overrides.
// Depends on gcpa_pkg.
module gcpa_scale (
  input  logic [63:0]           p_i,
  input  logic signed [7:0]     n_i,
  input  gcpa_pkg::gcpa_range_t range_i,
  input  logic                  spot_zero_i,
  output logic [63:0]           price_o,
  output logic                  sat_o
);
  import gcpa_pkg::*;

  logic signed [8:0] s;
  logic [8:0]        amt;
  logic [127:0]      wide;

  always_comb begin
    s       = {n_i[7], n_i} - 9'sd30;
    amt     = 9'(-s);
    wide    = {64'd0, p_i} << s[5:0];
    price_o = '0;
    sat_o   = 1'b0;
    if (range_i.hi) begin
      price_o = spot_zero_i ? 64'd0 : '1;
      sat_o   = !spot_zero_i;
    end else if (range_i.lo) begin
      price_o = '0;
    end else if (!s[8]) begin
      if (p_i != 64'd0 && wide[127:64] != 64'd0) begin
        price_o = '1;
        sat_o   = 1'b1;
      end else begin
        price_o = wide[63:0];
      end
    end else if (amt[8:6] == 3'd0) begin
      price_o = p_i >> amt[5:0];
    end
  end

endmodule

[rtl/core/gbm_call_payoff_accumulator_top.sv]
// Top level: GBM call payoff accumulator, sequencer, registers and accumulator.
// Depends on gcpa_pkg, gcpa_mul, gcpa_rom, gcpa_scale.
//
// channel   dir  handshake              payload
// config    in   cfg_we_i               cfg_idx_i, cfg_data_i
// sample    in   s_axis_tvalid/tready   tdata: normal_sample; tlast: last_sample
// totals    out  m_axis_tvalid/tready   tdata: payoff_total, samples_done, overflowed
//
// One sample at a time: accept, then six sequencer steps that take
// turns on one shared multiplier (diffusion*z, x*log2e, spot*table) with a
// registered table read and a scaling step between. Totals sit in an output
// register; a last sample stalls in its final step while that is full and unread.
// Reset is asynchronous, active low, and loads the register defaults.
module gbm_call_payoff_accumulator_top #(
  parameter int unsigned EXP_TABLE_BITS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gcpa_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [gcpa_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [gcpa_pkg::SampleW-1:0]    s_axis_tdata,   // [15:0] normal_sample
  input  logic                            s_axis_tlast,   // last_sample
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [63:0] payoff_total, [103:64] samples_done, [104] overflowed, rest zero
  output logic [gcpa_pkg::OutDataW-1:0]   m_axis_tdata
);
  import gcpa_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXPO  = 7'b0000010,
    S_LOG2  = 7'b0000100,
    S_LOOK  = 7'b0001000,
    S_SCALE = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_ACCUM = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [PriceW-1:0]         spot_q, strike_q;
  logic signed [PriceW-1:0]  drift_q;
  logic [DiffW-1:0]          diff_q;

  logic signed [SampleW-1:0] z_q;
  logic                      last_q;
  logic signed [XW-1:0]      x_q;
  logic signed [YW-1:0]      y_q;
  gcpa_range_t               range_q;
  logic [63:0]               p_q;
  logic [63:0]               price_q;
  logic                      psat_q;

  logic [SumW-1:0]           sum_q;
  logic [CountW-1:0]         cnt_q;
  logic                      sat_q;
  logic [OutDataW-1:0]       out_data_q;
  logic                      out_valid_q;

  logic signed [MulW-1:0]    mul_a, mul_b;
  logic signed [ProdW-1:0]   mul_p;
  logic [31:0]               rom_data;
  logic [63:0]               price;
  logic                      price_sat;

  logic [63:0]               payoff;
  logic [SumW:0]             sum_ext;
  logic [SumW-1:0]           sum_new;
  logic                      sat_new;
  logic [CountW-1:0]         cnt_new;
  logic                      emit_ok;

  gcpa_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  gcpa_rom #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (y_q[15:16-EXP_TABLE_BITS]),
    .data_o (rom_data)
  );

  gcpa_scale u_scale (
    .p_i         (p_q),
    .n_i         (y_q[23:16]),
    .range_i     (range_q),
    .spot_zero_i (spot_q == '0),
    .price_o     (price),
    .sat_o       (price_sat)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_EXPO: begin
        mul_a = {2'b00, diff_q};
        mul_b = {{(MulW-SampleW){z_q[SampleW-1]}}, z_q};
      end
      S_LOG2: begin
        mul_a = {{(MulW-YW){x_q[YW-1]}}, x_q[YW-1:0]};
        mul_b = {2'b00, Log2eQ30};
      end
      S_SCALE: begin
        mul_a = {1'b0, spot_q};
        mul_b = {1'b0, rom_data};
      end
      default: ;
    endcase
  end

  // accumulate
  always_comb begin
    payoff  = (price_q > {32'd0, strike_q}) ? price_q - {32'd0, strike_q} : 64'd0;
    sum_ext = {1'b0, sum_q} + {1'b0, payoff};
    sum_new = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
    sat_new = sat_q | psat_q | sum_ext[SumW];
    cnt_new = (cnt_q == '1) ? cnt_q : cnt_q + CountW'(1);
    emit_ok = !last_q || !out_valid_q || m_axis_tready;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (s_axis_tvalid) state_d = S_EXPO;
      S_EXPO:  state_d = S_LOG2;
      S_LOG2:  state_d = S_LOOK;
      S_LOOK:  state_d = S_SCALE;
      S_SCALE: state_d = S_SHIFT;
      S_SHIFT: state_d = S_ACCUM;
      S_ACCUM: if (emit_ok) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spot_q   <= SpotReset;
      strike_q <= StrikeReset;
      drift_q  <= DriftReset;
      diff_q   <= DiffReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SPOT:   spot_q   <= cfg_data_i;
        CFG_STRIKE: strike_q <= cfg_data_i;
        CFG_DRIFT:  drift_q  <= cfg_data_i;
        CFG_DIFF:   diff_q   <= cfg_data_i[DiffW-1:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      z_q    <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
    if (state_q == S_EXPO) begin
      x_q <= {{(XW-PriceW){drift_q[PriceW-1]}}, drift_q} + {mul_p[46], mul_p[46:12]};
    end
    if (state_q == S_LOG2) begin
      y_q        <= mul_p[53:30];
      range_q.hi <= x_q > XLimit;
      range_q.lo <= x_q < -XLimit;
    end
    if (state_q == S_SCALE) begin
      p_q <= mul_p[63:0];
    end
    if (state_q == S_SHIFT) begin
      price_q <= price;
      psat_q  <= price_sat;
    end
    if (state_q == S_ACCUM && last_q && emit_ok) begin
      out_data_q <= {7'd0, sat_new, cnt_new, sum_new};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cnt_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_ACCUM && emit_ok) begin
        if (last_q) begin
          sum_q <= '0;
          cnt_q <= '0;
          sat_q <= 1'b0;
        end else begin
          sum_q <= sum_new;
          cnt_q <= cnt_new;
          sat_q <= sat_new;
        end
      end
      if (state_q == S_ACCUM && emit_ok && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[tb/sv/gcpa_payoff_checker.sv]
// Checker for the GBM call payoff accumulator: watches config writes and both streams,
// predicts the run totals and compares every totals transaction field by field.
// Depends on gcpa_pkg for the register index names.
module gcpa_payoff_checker #(
  parameter int unsigned ExpTableBits = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [15:0]  s_data_i,   // [15:0] normal_sample
  input  logic         s_last_i,   // last_sample
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  // [63:0] payoff_total, [103:64] samples_done, [104] overflowed, rest zero
  input  logic [111:0] m_data_i,
  output int           fail_count_o,
  output int           pending_o
);

  localparam longint          Log2eQ30     = 64'sd1549082005;
  localparam logic [63:0]     Ln2Q32       = 64'd2977044472;
  localparam longint          ExpLimit     = 64'sd4194304;  // 64.0 in Q16.16
  localparam logic [31:0]     SpotDefault  = 32'd6553600;
  localparam logic [31:0]     StrikeDefault = 32'd6553600;
  localparam logic [31:0]     DriftDefault = 32'd1966;
  localparam logic [30:0]     DiffDefault  = 31'd13107;

  typedef struct packed {
    logic [63:0] total;
    logic [39:0] count;
    logic        ovf;
  } run_totals_t;

  logic [31:0]        spot;
  logic [31:0]        strike;
  logic signed [31:0] drift;
  logic [30:0]        diffusion;
  logic [63:0]        payoff_sum;
  logic [39:0]        sample_count;
  logic               sat_seen;
  run_totals_t        expected_totals[$];
  logic [31:0]        exp_frac [1 << ExpTableBits];

  // 2^(i / 2^bits) in Q2.30 from a series of exp(i / 2^bits * ln2) up to the 12th-order term
  function automatic logic [31:0] frac_power(input int unsigned i);
    logic [63:0] u, t, term, acc;
    u    = 64'(i) << (32 - ExpTableBits);
    t    = (u * Ln2Q32) >> 32;
    term = 64'd1 << 32;
    acc  = term;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * t) >> 32) / 64'(k);
      acc  = acc + term;
    end
    return 32'((acc + 64'd2) >> 2);
  endfunction

  initial begin
    for (int i = 0; i < (1 << ExpTableBits); i++) exp_frac[i] = frac_power(i);
  end

  function automatic logic [63:0] terminal_price(input logic signed [15:0] z, output logic sat);
    longint      x, y, n, sh, frac;
    logic [63:0] p;
    sat = 1'b0;
    x = longint'(drift) + ((longint'(diffusion) * longint'(z)) >>> 12);
    if (x > ExpLimit) begin
      if (spot == '0) return '0;
      sat = 1'b1;
      return '1;
    end
    if (x < -ExpLimit) return '0;
    y    = (x * Log2eQ30) >>> 30;
    n    = y >>> 16;
    frac = y - n * 65536;
    p    = 64'(spot) * 64'(exp_frac[int'(frac) >> (16 - ExpTableBits)]);
    sh   = n - 30;
    if (sh >= 0) begin
      if (p == '0) return '0;
      if (sh >= 64 || p > (64'hFFFF_FFFF_FFFF_FFFF >> sh)) begin
        sat = 1'b1;
        return '1;
      end
      return p << sh;
    end
    if (-sh >= 64) return '0;
    return p >> (-sh);
  endfunction

  task automatic accumulate(input logic [15:0] z, input logic last);
    logic [63:0] price, payoff;
    logic        sat;
    price  = terminal_price($signed(z), sat);
    payoff = (price > 64'(strike)) ? price - 64'(strike) : '0;
    if (sat) sat_seen = 1'b1;
    if (payoff > ~payoff_sum) begin
      payoff_sum = '1;
      sat_seen   = 1'b1;
    end else begin
      payoff_sum = payoff_sum + payoff;
    end
    if (sample_count != '1) sample_count = sample_count + 40'd1;
    if (last) begin
      expected_totals.push_back('{total: payoff_sum, count: sample_count, ovf: sat_seen});
      payoff_sum   = '0;
      sample_count = '0;
      sat_seen     = 1'b0;
    end
  endtask

  task automatic check_totals(input logic [111:0] data);
    run_totals_t want;
    if (expected_totals.size() == 0) begin
      $error("totals transaction with none expected: %0h", data);
      fail_count_o++;
      return;
    end
    want = expected_totals.pop_front();
    if (data[63:0] !== want.total) begin
      $error("payoff_total: expected %0h, got %0h", want.total, data[63:0]);
      fail_count_o++;
    end
    if (data[103:64] !== want.count) begin
      $error("samples_done: expected %0d, got %0d", want.count, data[103:64]);
      fail_count_o++;
    end
    if (data[104] !== want.ovf) begin
      $error("overflowed: expected %0b, got %0b", want.ovf, data[104]);
      fail_count_o++;
    end
    if (data[111:105] !== '0) begin
      $error("padding: expected 0, got %0h", data[111:105]);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spot         = SpotDefault;
      strike       = StrikeDefault;
      drift        = DriftDefault;
      diffusion    = DiffDefault;
      payoff_sum   = '0;
      sample_count = '0;
      sat_seen     = 1'b0;
      expected_totals.delete();
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gcpa_pkg::CFG_SPOT:   spot      = cfg_data_i;
          gcpa_pkg::CFG_STRIKE: strike    = cfg_data_i;
          gcpa_pkg::CFG_DRIFT:  drift     = cfg_data_i;
          gcpa_pkg::CFG_DIFF:   diffusion = cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) accumulate(s_data_i, s_last_i);
      if (m_valid_i && m_ready_i) check_totals(m_data_i);
      pending_o = expected_totals.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
// Testbench top for gbm_call_payoff_accumulator_top: clock, reset, register setup,
// sample stimulus and output backpressure; checking is done in gcpa_payoff_checker.
// Depends on gcpa_pkg, the accumulator RTL and gcpa_payoff_checker.
module testbench;

  localparam int unsigned TableBits     = 10;
  localparam int          SettleCycles  = 16;
  localparam int          RandomPhases  = 8;
  localparam int          ItemsPerPhase = 67;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [31:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata;   // [15:0] normal_sample
  logic         s_axis_tlast;   // last_sample
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // [63:0] payoff_total, [103:64] samples_done, [104] overflowed, rest zero
  logic [111:0] m_axis_tdata;
  logic         no_gaps;
  int           fail_count;
  int           pending;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  gbm_call_payoff_accumulator_top #(
    .EXP_TABLE_BITS(TableBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  gcpa_payoff_checker #(
    .ExpTableBits(TableBits)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_last_i    (s_axis_tlast),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(negedge clk_i) m_axis_tready <= no_gaps || ($urandom_range(99) >= 27);

  task automatic write_reg(input gcpa_pkg::cfg_idx_e idx, input logic [31:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  // caller stands at a falling edge; returns at the falling edge after acceptance
  task automatic send_sample(input logic [15:0] z, input logic last);
    if (!no_gaps) begin
      while ($urandom_range(99) < 27) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = z;
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value(input logic [31:0] lo, input logic [31:0] hi,
                                             input logic [31:0] typical);
    case ($urandom_range(9))
      0:       return lo;
      1:       return hi;
      2:       return $urandom();
      default: return typical;
    endcase
  endfunction

  task automatic randomize_regs();
    logic [31:0] spot;
    spot = pick_value('0, '1, $urandom_range(32'h00C8_0000, 32'h0001_0000));
    write_reg(gcpa_pkg::CFG_SPOT, spot);
    write_reg(gcpa_pkg::CFG_STRIKE,
              pick_value('0, '1, spot + $urandom_range(32'h0028_0000) - 32'h0014_0000));
    write_reg(gcpa_pkg::CFG_DRIFT, pick_value(32'h8000_0000, 32'h7FFF_FFFF,
                                              $urandom_range(32'h0002_0000) - 32'h0001_0000));
    write_reg(gcpa_pkg::CFG_DIFF, pick_value('0, 32'h7FFF_FFFF, $urandom_range(32'h0001_0000)));
  endtask

  function automatic logic [15:0] random_sample();
    if ($urandom_range(9) < 7) return 16'($urandom_range(32'h6000) - 32'h3000);
    return 16'($urandom());
  endfunction

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = gcpa_pkg::CFG_SPOT;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    no_gaps       = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // register defaults, sample extremes and bit patterns
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b1);
    send_sample(16'h0000, 1'b1);
    settle();

    // exponent above and below range, then sum saturation
    write_reg(gcpa_pkg::CFG_SPOT, 32'hFFFF_FFFF);
    write_reg(gcpa_pkg::CFG_STRIKE, 32'h0000_0000);
    write_reg(gcpa_pkg::CFG_DRIFT, 32'h0000_0000);
    write_reg(gcpa_pkg::CFG_DIFF, 32'hFFFF_FFFF);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    settle();

    // zero spot with exponent too high: price 0, no flag
    write_reg(gcpa_pkg::CFG_SPOT, 32'h0000_0000);
    send_sample(16'h7FFF, 1'b1);
    settle();

    // shift overflow, exact limits and drift extremes with no diffusion
    write_reg(gcpa_pkg::CFG_SPOT, 32'hFFFF_FFFF);
    write_reg(gcpa_pkg::CFG_STRIKE, 32'hFFFF_FFFF);
    write_reg(gcpa_pkg::CFG_DIFF, 32'h0000_0000);
    write_reg(gcpa_pkg::CFG_DRIFT, 32'h003C_0000);
    send_sample(16'h1234, 1'b1);
    settle();
    write_reg(gcpa_pkg::CFG_DRIFT, 32'h0040_0000);
    send_sample(16'h8000, 1'b1);
    settle();
    write_reg(gcpa_pkg::CFG_DRIFT, 32'h7FFF_FFFF);
    send_sample(16'h7FFF, 1'b1);
    settle();
    write_reg(gcpa_pkg::CFG_DRIFT, 32'hFFC0_0000);
    send_sample(16'h0000, 1'b1);
    settle();
    write_reg(gcpa_pkg::CFG_DRIFT, 32'h8000_0000);
    send_sample(16'hFFFF, 1'b1);
    settle();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      no_gaps = (ph == 2);
      randomize_regs();
      for (int k = 0; k < ItemsPerPhase; k++)
        send_sample(random_sample(), (k == ItemsPerPhase - 1) || ($urandom_range(7) == 0));
      settle();
    end
    no_gaps = 1'b0;

    if (fail_count == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("testbench: errors");
    $finish;
  end

endmodule
